// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 32768;
	localparam int HEADER_BYTES   = 16;
	localparam int ALIGN_BYTES    = 8;
	localparam int ALIGN_SH       = $clog2(ALIGN_BYTES);
	localparam int MIN_HEAP       = 64;
	localparam logic [15:0] CFG_RESET = 16'd32768;

	// operation codes
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;
	localparam logic [1:0] OP_COUNT = 2'd3;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] amount;
		logic [14:0] address;
		logic [7:0]  task_id;
		logic        privileged;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [14:0] payload_offset;
		logic [12:0] block_count;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap manager with block splitting and coalescing on free
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result comes
// back later on the result port, flagged by done for exactly one cycle, and
// the receiver cannot hold it off. Block headers live in one ram, one entry
// per aligned offset, and every request except init and a zero-size allocate
// walks the block chain one ram read per cycle; free reads one more header
// when a following block exists, and splitting adds one more write. The
// registered ram read sets the walk rate.
`default_nettype none

module first_fit_heap_allocator #(
	parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire ffha_pkg::request_t request,
	output logic                    done,
	output ffha_pkg::result_t       result,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata
);

	localparam int DEPTH = HEAP_BYTES / ffha_pkg::ALIGN_BYTES;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int NXT_W = IDX_W + 1;
	localparam int SZ_W  = 16;
	localparam int REC_W = 1 + 8 + NXT_W + SZ_W;
	localparam logic [SZ_W:0] HDR = (SZ_W+1)'(ffha_pkg::HEADER_BYTES);
	localparam logic [NXT_W-1:0] END_MARK = {1'b1, {IDX_W{1'b0}}};

	// state codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_NEXT  = 3'd3;

	// usable heap size: rounded down to a multiple of 8, clamped to the supported range
	function automatic logic [SZ_W:0] heap_total(input logic [15:0] hb);
		logic [SZ_W:0] t;
		t = {1'b0, hb[15:3], 3'b000};
		if (t < (SZ_W+1)'(ffha_pkg::MIN_HEAP)) t = (SZ_W+1)'(ffha_pkg::MIN_HEAP);
		if (t > (SZ_W+1)'(HEAP_BYTES)) t = (SZ_W+1)'(HEAP_BYTES);
		return t;
	endfunction

	localparam logic [SZ_W:0] RST_TOTAL = heap_total(ffha_pkg::CFG_RESET);

	// registers
	logic [2:0]       state_q;
	logic [15:0]      heap_bytes_q;
	logic             e0_valid_q;   // entry 0 has been written since reset
	logic             rd_is0_q;
	logic [1:0]       op_q;
	logic [15:0]      amt_q;
	logic [14:0]      addr_q;
	logic [7:0]       task_q;
	logic             priv_q;
	logic [SZ_W:0]    req_q;        // aligned allocate size
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] nb_q;
	logic [NXT_W-1:0] x_next_q;     // next of the target block
	logic [SZ_W-1:0]  x_size_q;
	logic             prev_ok_q;
	logic             prev_free_q;
	logic [IDX_W-1:0] prev_idx_q;
	logic [SZ_W-1:0]  prev_size_q;
	logic [12:0]      cnt_q;
	logic             done_q;
	logic             status_q;
	logic [14:0]      pay_q;

	// ram ports
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [REC_W-1:0] wr_rec;
	logic [IDX_W-1:0] rd_idx;
	logic [REC_W-1:0] ram_q;

	ffha_ram #(
		.WIDTH(REC_W),
		.DEPTH(DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_rec),
		.raddr(rd_idx),
		.rdata(ram_q)
	);

	// header read back, with entry 0 shown at its reset value until written
	logic             rd_free;
	logic [7:0]       rd_owner;
	logic [NXT_W-1:0] rd_next;
	logic [SZ_W-1:0]  rd_size;
	logic             rd_end;

	always_comb begin
		if (rd_is0_q && !e0_valid_q) begin
			rd_free  = 1'b1;
			rd_owner = 8'd0;
			rd_next  = END_MARK;
			rd_size  = SZ_W'(RST_TOTAL - HDR);
		end else begin
			{rd_free, rd_owner, rd_next, rd_size} = ram_q;
		end
		rd_end = rd_next[IDX_W];
	end

	// per-cycle decisions
	logic [SZ_W:0]    slack;        // block size minus request
	logic             fits;
	logic [SZ_W:0]    pay_full;
	logic             hit;
	logic [IDX_W-1:0] nb_idx;
	logic [SZ_W:0]    init_total;
	logic             merge_prev;
	logic [IDX_W-1:0] m_idx;
	logic [SZ_W:0]    m_size;
	logic [NXT_W-1:0] m_next;
	logic             n_free;

	always_comb begin
		slack      = {1'b0, rd_size} - req_q;
		fits       = rd_free && (req_q <= {1'b0, rd_size});
		pay_full   = (SZ_W+1)'({cur_q, {ffha_pkg::ALIGN_SH{1'b0}}}) + HDR;
		hit        = (pay_full == {2'b00, addr_q});
		nb_idx     = cur_q + IDX_W'((req_q + HDR) >> ffha_pkg::ALIGN_SH);
		init_total = heap_total(heap_bytes_q);

		// coalesce: absorb into a free previous block, then take a free follower
		merge_prev = prev_ok_q && prev_free_q;
		n_free     = (state_q == ST_NEXT) && rd_free;
		m_idx      = merge_prev ? prev_idx_q : cur_q;
		m_size     = merge_prev ? ({1'b0, prev_size_q} + {1'b0, x_size_q} + HDR)
		                        : {1'b0, x_size_q};
		m_next     = x_next_q;
		if (n_free) begin
			m_size = m_size + {1'b0, rd_size} + HDR;
			m_next = rd_next;
		end
	end

	// ram write and read address
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = cur_q;
		wr_rec = '0;
		rd_idx = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_idx = '0;
				if (start && request.op == ffha_pkg::OP_INIT) begin
					wr_en  = 1'b1;
					wr_idx = '0;
					wr_rec = {1'b1, 8'd0, END_MARK, SZ_W'(init_total - HDR)};
				end
			end
			ST_WALK: begin
				rd_idx = rd_next[IDX_W-1:0];
				if (op_q == ffha_pkg::OP_ALLOC && fits) begin
					wr_en = 1'b1;
					if (slack >= HDR) begin
						// split: write the new free remainder first
						wr_idx = nb_idx;
						wr_rec = {1'b1, 8'd0, rd_next, SZ_W'(slack - HDR)};
					end else begin
						wr_idx = cur_q;
						wr_rec = {1'b0, task_q, rd_next, rd_size};
					end
				end else if (op_q == ffha_pkg::OP_FREE && hit && !rd_free
				             && (priv_q || rd_owner == task_q) && rd_end) begin
					// no follower: merge with previous only
					wr_en  = 1'b1;
					wr_idx = merge_prev ? prev_idx_q : cur_q;
					wr_rec = merge_prev
						? {1'b1, 8'd0, rd_next,
						   SZ_W'({1'b0, prev_size_q} + {1'b0, rd_size} + HDR)}
						: {1'b1, rd_owner, rd_next, rd_size};
				end
			end
			ST_SPLIT: begin
				wr_en  = 1'b1;
				wr_idx = cur_q;
				wr_rec = {1'b0, task_q, {1'b0, nb_q}, SZ_W'(req_q)};
			end
			ST_NEXT: begin
				wr_en  = 1'b1;
				wr_idx = m_idx;
				wr_rec = {1'b1, 8'd0, m_next, SZ_W'(m_size)};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			heap_bytes_q <= ffha_pkg::CFG_RESET;
			e0_valid_q   <= 1'b0;
			rd_is0_q     <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ffha_pkg::STATUS_OK;
			pay_q        <= '0;
			cnt_q        <= '0;
			prev_ok_q    <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_is0_q <= (rd_idx == '0);
			if (cfg_we) begin
				heap_bytes_q <= cfg_wdata;
			end
			if (wr_en && wr_idx == '0) begin
				e0_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q      <= request.op;
						amt_q     <= request.amount;
						addr_q    <= request.address;
						task_q    <= request.task_id;
						priv_q    <= request.privileged;
						// round the request up to the alignment
						req_q     <= ({1'b0, request.amount}
						              + (SZ_W+1)'(ffha_pkg::ALIGN_BYTES - 1))
						             & ~(SZ_W+1)'(ffha_pkg::ALIGN_BYTES - 1);
						cur_q     <= '0;
						cnt_q     <= '0;
						prev_ok_q <= 1'b0;
						pay_q     <= '0;
						status_q  <= ffha_pkg::STATUS_OK;
						if (request.op == ffha_pkg::OP_INIT) begin
							done_q <= 1'b1;
						end else if (request.op == ffha_pkg::OP_ALLOC
						             && request.amount == 16'd0) begin
							// zero-size request fails at once
							status_q <= ffha_pkg::STATUS_FAIL;
							done_q   <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					case (op_q)
						ffha_pkg::OP_ALLOC: begin
							if (fits) begin
								pay_q <= pay_full[14:0];
								if (slack >= HDR) begin
									nb_q    <= nb_idx;
									state_q <= ST_SPLIT;
								end else begin
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end
							end else if (rd_end) begin
								status_q <= ffha_pkg::STATUS_FAIL;
								done_q   <= 1'b1;
								state_q  <= ST_IDLE;
							end else begin
								cur_q <= rd_next[IDX_W-1:0];
							end
						end
						ffha_pkg::OP_FREE: begin
							if (hit) begin
								x_next_q <= rd_next;
								x_size_q <= rd_size;
								if (rd_free || (!priv_q && rd_owner != task_q)) begin
									// double free or foreign owner
									status_q <= ffha_pkg::STATUS_FAIL;
									done_q   <= 1'b1;
									state_q  <= ST_IDLE;
								end else if (rd_end) begin
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									state_q <= ST_NEXT;
								end
							end else if (rd_end) begin
								// unknown address
								status_q <= ffha_pkg::STATUS_FAIL;
								done_q   <= 1'b1;
								state_q  <= ST_IDLE;
							end else begin
								prev_ok_q   <= 1'b1;
								prev_free_q <= rd_free;
								prev_idx_q  <= cur_q;
								prev_size_q <= rd_size;
								cur_q       <= rd_next[IDX_W-1:0];
							end
						end
						default: begin
							if (rd_free && ({1'b0, rd_size} + HDR) < {1'b0, amt_q}
							    && cnt_q != 13'h1fff) begin
								cnt_q <= cnt_q + 13'd1;
							end
							if (rd_end) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								cur_q <= rd_next[IDX_W-1:0];
							end
						end
					endcase
				end
				ST_SPLIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_NEXT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy                  = (state_q != ST_IDLE);
	assign done                  = done_q;
	assign result.status         = status_q;
	assign result.payload_offset = pay_q;
	assign result.block_count    = (op_q == ffha_pkg::OP_COUNT) ? cnt_q : 13'd0;

endmodule

`default_nettype wire

// ===== bench/heap_checker.sv =====
// ----------------------------------------------------------------------------
// heap_checker
// predicts every allocator result from accepted requests and compares them
// ----------------------------------------------------------------------------
`default_nettype none

module heap_checker
	import ffha_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire request_t   request,
	input  wire logic       done,
	input  wire result_t    result,
	input  wire logic       cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = HEAP_BYTES_DEF + 1;
	localparam int CHAIN_END = -1;

	logic [15:0] heap_reg;
	int unsigned hdr_size [SLOTS];
	bit          hdr_free [SLOTS];
	logic [7:0]  hdr_owner[SLOTS];
	int          hdr_next [SLOTS];
	result_t     results_due[$];

	function automatic bit valid_slot(int b);
		return b >= 0 && b < SLOTS;
	endfunction

	function automatic int heap_total();
		int t;
		t = int'(heap_reg) & ~7;
		if (t < MIN_HEAP) t = MIN_HEAP;
		if (t > HEAP_BYTES_DEF) t = HEAP_BYTES_DEF;
		return t;
	endfunction

	task automatic build_heap();
		int t;
		t = heap_total();
		for (int i = 0; i <= t; i++) begin
			hdr_size[i] = 0;
			hdr_free[i] = 0;
			hdr_owner[i] = '0;
			hdr_next[i] = 0;
		end
		hdr_size[0] = t - HEADER_BYTES;
		hdr_free[0] = 1;
		hdr_next[0] = CHAIN_END;
	endtask

	task automatic alloc_block(input request_t rq, inout result_t rs);
		int unsigned need;
		int cur;
		int nb;
		need = rq.amount;
		cur = 0;
		if (need == 0) return;
		need = (need + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
		while (valid_slot(cur) && !(hdr_free[cur] && need <= hdr_size[cur]))
			cur = hdr_next[cur];
		if (!valid_slot(cur)) return;
		// split unless the leftover cannot hold a header
		if (hdr_size[cur] - need >= HEADER_BYTES) begin
			nb = cur + HEADER_BYTES + need;
			hdr_free[nb] = 1;
			hdr_size[nb] = hdr_size[cur] - need - HEADER_BYTES;
			hdr_next[nb] = hdr_next[cur];
			hdr_owner[nb] = '0;
			hdr_size[cur] = need;
			hdr_next[cur] = nb;
		end
		hdr_free[cur] = 0;
		hdr_owner[cur] = rq.task_id;
		rs.status = STATUS_OK;
		rs.payload_offset = 15'(cur + HEADER_BYTES);
	endtask

	task automatic absorb(int a, int b);
		hdr_size[a] = hdr_size[a] + hdr_size[b] + HEADER_BYTES;
		hdr_next[a] = hdr_next[b];
	endtask

	task automatic free_block(input request_t rq, output logic st);
		int cur;
		int prev;
		int nx;
		cur = 0;
		prev = CHAIN_END;
		st = STATUS_FAIL;
		while (1) begin
			if (!valid_slot(cur)) return;
			if (cur + HEADER_BYTES == int'(rq.address)) break;
			prev = cur;
			cur = hdr_next[cur];
		end
		if (hdr_free[cur]) return;
		if (!rq.privileged && hdr_owner[cur] != rq.task_id) return;
		hdr_free[cur] = 1;
		if (valid_slot(prev) && hdr_free[prev]) begin
			absorb(prev, cur);
			cur = prev;
		end
		nx = hdr_next[cur];
		if (valid_slot(nx) && hdr_free[nx]) absorb(cur, nx);
		st = STATUS_OK;
	endtask

	function automatic logic [12:0] count_small(int unsigned thr);
		int cur;
		int cnt;
		cur = 0;
		cnt = 0;
		while (valid_slot(cur)) begin
			if (hdr_free[cur] && hdr_size[cur] + HEADER_BYTES < thr && cnt < 8191) cnt++;
			cur = hdr_next[cur];
		end
		return 13'(cnt);
	endfunction

	task automatic predict(input request_t rq);
		result_t rs;
		rs = '0;
		case (rq.op)
			OP_INIT: build_heap();
			OP_ALLOC: begin
				rs.status = STATUS_FAIL;
				alloc_block(rq, rs);
			end
			OP_FREE: free_block(rq, rs.status);
			default: rs.block_count = count_small(rq.amount);
		endcase
		results_due.push_back(rs);
	endtask

	task automatic report(string what, int got, int want);
		$display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			errors = 0;
			heap_reg = CFG_RESET;
			build_heap();
			results_due.delete();
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					report("unexpected result, status", result.status, 0);
				end else begin
					want = results_due.pop_front();
					if (result.status !== want.status)
						report("status", result.status, want.status);
					if (result.payload_offset !== want.payload_offset)
						report("payload_offset", result.payload_offset, want.payload_offset);
					if (result.block_count !== want.block_count)
						report("block_count", result.block_count, want.block_count);
				end
			end
			if (start && !busy) predict(request);
			if (cfg_we) heap_reg = cfg_wdata;
		end
		pending = results_due.size();
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// directed and random request streams against the first-fit heap allocator
// ----------------------------------------------------------------------------
// Drives init, allocate, free and count requests through several heap sizes
// and idle patterns; the checker beside the block predicts each result and
// counts mismatches, and this module gives the verdict.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	request_t    request;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          errors;
	int          pending;

	// payload offsets handed out so far, used to build legal frees
	logic [14:0] live_blocks[$];
	// percent chance of a sender gap in the current phase
	int          idle_pct;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	heap_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// harvest successful allocations for later frees
	always @(posedge clk) begin
		if (arst_n && done && result.status == STATUS_OK && result.payload_offset != 0)
			live_blocks.push_back(result.payload_offset);
	end

	// hold start until the block takes the request, then maybe idle a while
	task automatic send(input logic [1:0] op, input logic [15:0] amount,
			input logic [14:0] address, input logic [7:0] task_id, input logic priv);
		int gap;
		start <= 1'b1;
		request <= '{op: op, amount: amount, address: address,
			task_id: task_id, privileged: priv};
		do @(posedge clk); while (busy);
		if (op == OP_INIT) live_blocks.delete();
		if ($urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// registers change only with the block idle, then the heap is rebuilt
	task automatic set_heap(input logic [15:0] bytes);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= bytes;
		@(posedge clk);
		cfg_we <= 1'b0;
		send(OP_INIT, '0, '0, '0, 1'b0);
	endtask

	task automatic random_request();
		int pick;
		int k;
		logic [7:0] tid;
		logic [15:0] amt;
		logic [14:0] addr;
		pick = $urandom_range(99);
		// mostly a handful of tasks so ownership checks pass now and then
		tid = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		if (pick < 45) begin
			case ($urandom_range(9))
				0: amt = 16'($urandom);
				1: amt = 16'($urandom_range(2048));
				default: amt = 16'($urandom_range(160));
			endcase
			send(OP_ALLOC, amt, 15'($urandom), tid, 1'($urandom_range(9) == 0));
		end else if (pick < 85) begin
			if (live_blocks.size() != 0 && $urandom_range(9) < 8) begin
				k = $urandom_range(live_blocks.size() - 1);
				addr = live_blocks[k];
				if ($urandom_range(3) != 0) live_blocks.delete(k);
			end else if ($urandom_range(1)) begin
				addr = 15'($urandom);
			end else begin
				addr = 15'(16 + 8 * $urandom_range(300));
			end
			send(OP_FREE, 16'($urandom), addr, tid, 1'($urandom_range(6) == 0));
		end else if (pick < 97) begin
			amt = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(300));
			send(OP_COUNT, amt, 15'($urandom), tid, 1'($urandom));
		end else begin
			send(OP_INIT, 16'($urandom), 15'($urandom), tid, 1'($urandom));
		end
	endtask

	initial begin
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset heap, zero request, no fit, widest fields
		send(OP_COUNT, 16'hFFFF, '0, '0, 1'b0);
		send(OP_ALLOC, 16'd0, '0, 8'd1, 1'b0);
		send(OP_ALLOC, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b1);
		send(OP_ALLOC, 16'd1, '0, 8'hFF, 1'b0);
		send(OP_ALLOC, 16'd24, '0, 8'd2, 1'b0);
		send(OP_FREE, '0, 15'h7FFF, 8'hFF, 1'b1);        // unknown address
		send(OP_FREE, '0, 15'd16, 8'd2, 1'b0);           // foreign free
		send(OP_FREE, '0, 15'd16, 8'hFF, 1'b0);          // owner frees
		send(OP_FREE, '0, 15'd16, 8'hFF, 1'b0);          // double free
		send(OP_FREE, '0, 15'd40, 8'd9, 1'b1);           // privileged, merges both ways
		send(OP_COUNT, 16'd0, '0, '0, 1'b0);

		// smallest heap: 48 byte block, a 32 byte grab leaves an empty split block
		set_heap(16'd64);
		send(OP_ALLOC, 16'd32, '0, 8'd5, 1'b0);
		send(OP_COUNT, 16'd17, '0, '0, 1'b0);
		send(OP_ALLOC, 16'd1, '0, 8'd5, 1'b0);
		send(OP_FREE, '0, 15'd16, 8'd5, 1'b0);
		send(OP_ALLOC, 16'd48, '0, 8'd6, 1'b0);
		send(OP_ALLOC, 16'd8, '0, 8'd6, 1'b0);
		set_heap(16'hFFFF);                              // clamps to the full heap
		set_heap(16'd0);                                 // clamps up to the minimum
		send(OP_ALLOC, 16'd49, '0, 8'd7, 1'b0);

		// random phases over a spread of heap sizes and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 55;
				2: idle_pct = 0;
				default: idle_pct = 38;
			endcase
			case (ph)
				0: set_heap(16'd512);
				1: set_heap(16'd1003);
				2: set_heap(16'd256);
				3: set_heap(16'd64);
				4: set_heap(16'($urandom_range(2048, 64)));
				5: set_heap(16'd32768);
				6: set_heap(16'($urandom));
				default: set_heap(16'd768);
			endcase
			for (int i = 0; i < 100; i++) begin
				random_request();
				// once in a while let the pipe run dry
				if ($urandom_range(49) == 0) drain();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (pending != 0) $display("error: %0d results never arrived", pending);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#200ms;
		$display("timeout waiting on the allocator");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
